[rtl/lfsrn_pkg.sv]
// lfsrn_pkg: shared types and constants of the lfsr noise channel
// used by lfsrn_core and lfsr_noise_channel; depends on nothing

package lfsrn_pkg;

    // item kinds, carried on the input tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_FREQ  = 2'd1;
    localparam logic [1:0] OP_LEN   = 2'd2;
    localparam logic [1:0] OP_ENV   = 2'd3;

    // channel register indexes
    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_ENV    = 2'd1;
    localparam logic [1:0] REG_POLY   = 2'd2;
    localparam logic [1:0] REG_CTRL   = 2'd3;

    localparam int DIV_COUNT = 8;
    localparam int DIV_IDX_W = 3;
    localparam int DIV_W     = 8;
    localparam int SHIFT_W   = 4;
    // largest reload is 255 << 15, which needs 23 bits
    localparam int CNT_W     = DIV_W + (1 << SHIFT_W) - 1;
    localparam int LFSR_W    = 15;
    localparam int LEN_W     = 7;
    localparam int VOL_W     = 4;
    localparam int EPER_W    = 3;

    localparam logic [LFSR_W-1:0] LFSR_SEED  = 15'h7FFF;
    localparam int                NARROW_TAP = 6;
    localparam logic [LEN_W-1:0]  LEN_FULL   = 7'd64;
    localparam logic [VOL_W-1:0]  VOL_MAX    = 4'd15;

    typedef logic [DIV_W-1:0] div_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] reg_index;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic             channel_on;
        logic [VOL_W-1:0] sample_level;
    } result_t;

    // divisor reset values per selector code
    function automatic div_t div_default(input logic [DIV_IDX_W-1:0] sel);
        div_t d;
        case (sel)
            3'd0:    d = 8'd8;
            3'd1:    d = 8'd16;
            3'd2:    d = 8'd32;
            3'd3:    d = 8'd48;
            3'd4:    d = 8'd64;
            3'd5:    d = 8'd80;
            3'd6:    d = 8'd96;
            default: d = 8'd112;
        endcase
        return d;
    endfunction

endpackage

[rtl/lfsrn_core.sv]
// lfsrn_core: channel state and its combinational update for one item
// depends on lfsrn_pkg

module lfsrn_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lfsrn_pkg::DIV_IDX_W-1:0] cfg_index,
    input  logic [lfsrn_pkg::DIV_W-1:0]     cfg_data,
    input  logic                            en,
    input  lfsrn_pkg::item_t                item,
    output lfsrn_pkg::result_t              result
);

    lfsrn_pkg::div_t div_reg [lfsrn_pkg::DIV_COUNT];

    logic [lfsrn_pkg::CNT_W-1:0]     freq_cnt_reg,   freq_cnt_next;
    logic [lfsrn_pkg::LFSR_W-1:0]    lfsr_reg,       lfsr_next;
    logic                            narrow_reg,     narrow_next;
    logic [lfsrn_pkg::SHIFT_W-1:0]   shift_reg,      shift_next;
    logic [lfsrn_pkg::DIV_IDX_W-1:0] div_sel_reg,    div_sel_next;
    logic [lfsrn_pkg::LEN_W-1:0]     len_cnt_reg,    len_cnt_next;
    logic                            len_stop_reg,   len_stop_next;
    logic                            chan_on_reg,    chan_on_next;
    logic                            dac_on_reg,     dac_on_next;
    logic [lfsrn_pkg::VOL_W-1:0]     start_vol_reg,  start_vol_next;
    logic [lfsrn_pkg::VOL_W-1:0]     vol_reg,        vol_next;
    logic                            env_up_reg,     env_up_next;
    logic [lfsrn_pkg::EPER_W-1:0]    env_per_reg,    env_per_next;
    logic [lfsrn_pkg::EPER_W-1:0]    env_cnt_reg,    env_cnt_next;
    logic                            env_run_reg,    env_run_next;
    logic [lfsrn_pkg::VOL_W-1:0]     level_reg,      level_next;

    logic [lfsrn_pkg::CNT_W-1:0]  reload;
    logic [lfsrn_pkg::LFSR_W-1:0] lfsr_step;
    logic                         fb;

    // timer reload: selected divisor shifted by the clock shift
    assign reload = {{(lfsrn_pkg::CNT_W - lfsrn_pkg::DIV_W){1'b0}}, div_reg[div_sel_reg]}
                    << shift_reg;

    always_comb
    begin
        fb        = lfsr_reg[0] ^ lfsr_reg[1];
        lfsr_step = {fb, lfsr_reg[lfsrn_pkg::LFSR_W-1:1]};
        if (narrow_reg)
        begin
            lfsr_step[lfsrn_pkg::NARROW_TAP] = fb;
        end
    end

    always_comb
    begin
        freq_cnt_next  = freq_cnt_reg;
        lfsr_next      = lfsr_reg;
        narrow_next    = narrow_reg;
        shift_next     = shift_reg;
        div_sel_next   = div_sel_reg;
        len_cnt_next   = len_cnt_reg;
        len_stop_next  = len_stop_reg;
        chan_on_next   = chan_on_reg;
        dac_on_next    = dac_on_reg;
        start_vol_next = start_vol_reg;
        vol_next       = vol_reg;
        env_up_next    = env_up_reg;
        env_per_next   = env_per_reg;
        env_cnt_next   = env_cnt_reg;
        env_run_next   = env_run_reg;
        level_next     = level_reg;

        case (item.op)
            lfsrn_pkg::OP_WRITE:
            begin
                case (item.reg_index)
                    lfsrn_pkg::REG_LENGTH:
                    begin
                        len_cnt_next = {1'b0, item.write_data[5:0]};
                    end
                    lfsrn_pkg::REG_ENV:
                    begin
                        dac_on_next    = (item.write_data[7:3] != 5'd0);
                        start_vol_next = item.write_data[7:4];
                        vol_next       = item.write_data[7:4];
                        env_up_next    = item.write_data[3];
                        env_per_next   = item.write_data[2:0];
                        env_cnt_next   = item.write_data[2:0];
                    end
                    lfsrn_pkg::REG_POLY:
                    begin
                        shift_next   = item.write_data[7:4];
                        narrow_next  = item.write_data[3];
                        div_sel_next = item.write_data[2:0];
                    end
                    default:
                    begin
                        len_stop_next = item.write_data[6];
                        // restart
                        if (item.write_data[7])
                        begin
                            chan_on_next = 1'b1;
                            if (len_cnt_reg == '0)
                            begin
                                len_cnt_next = lfsrn_pkg::LEN_FULL;
                            end
                            freq_cnt_next = reload;
                            env_run_next  = 1'b1;
                            env_cnt_next  = env_per_reg;
                            vol_next      = start_vol_reg;
                            lfsr_next     = lfsrn_pkg::LFSR_SEED;
                        end
                    end
                endcase
            end
            lfsrn_pkg::OP_FREQ:
            begin
                // expires when the decrement reaches zero or below
                if (freq_cnt_reg > lfsrn_pkg::CNT_W'(1))
                begin
                    freq_cnt_next = freq_cnt_reg - lfsrn_pkg::CNT_W'(1);
                end
                else
                begin
                    freq_cnt_next = reload;
                    lfsr_next     = lfsr_step;
                    level_next    = (!lfsr_step[0] && chan_on_reg && dac_on_reg) ?
                                    vol_reg : '0;
                end
            end
            lfsrn_pkg::OP_LEN:
            begin
                if (len_cnt_reg != '0 && len_stop_reg)
                begin
                    len_cnt_next = len_cnt_reg - lfsrn_pkg::LEN_W'(1);
                    if (len_cnt_reg == lfsrn_pkg::LEN_W'(1))
                    begin
                        chan_on_next = 1'b0;
                    end
                end
            end
            default:
            begin
                if (env_cnt_reg > lfsrn_pkg::EPER_W'(1))
                begin
                    env_cnt_next = env_cnt_reg - lfsrn_pkg::EPER_W'(1);
                end
                else
                begin
                    env_cnt_next = env_per_reg;
                    if (env_run_reg && env_per_reg != '0)
                    begin
                        if (env_up_reg && vol_reg != lfsrn_pkg::VOL_MAX)
                        begin
                            vol_next = vol_reg + lfsrn_pkg::VOL_W'(1);
                        end
                        else if (!env_up_reg && vol_reg != '0)
                        begin
                            vol_next = vol_reg - lfsrn_pkg::VOL_W'(1);
                        end
                    end
                    if (vol_next == '0 || vol_next == lfsrn_pkg::VOL_MAX)
                    begin
                        env_run_next = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lfsrn_pkg::DIV_COUNT; i++)
            begin
                div_reg[i] <= lfsrn_pkg::div_default(lfsrn_pkg::DIV_IDX_W'(i));
            end
        end
        else if (cfg_we)
        begin
            div_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_cnt_reg  <= '0;
            lfsr_reg      <= '0;
            narrow_reg    <= 1'b0;
            shift_reg     <= '0;
            div_sel_reg   <= '0;
            len_cnt_reg   <= '0;
            len_stop_reg  <= 1'b0;
            chan_on_reg   <= 1'b0;
            dac_on_reg    <= 1'b0;
            start_vol_reg <= '0;
            vol_reg       <= '0;
            env_up_reg    <= 1'b0;
            env_per_reg   <= '0;
            env_cnt_reg   <= '0;
            env_run_reg   <= 1'b0;
            level_reg     <= '0;
        end
        else if (en)
        begin
            freq_cnt_reg  <= freq_cnt_next;
            lfsr_reg      <= lfsr_next;
            narrow_reg    <= narrow_next;
            shift_reg     <= shift_next;
            div_sel_reg   <= div_sel_next;
            len_cnt_reg   <= len_cnt_next;
            len_stop_reg  <= len_stop_next;
            chan_on_reg   <= chan_on_next;
            dac_on_reg    <= dac_on_next;
            start_vol_reg <= start_vol_next;
            vol_reg       <= vol_next;
            env_up_reg    <= env_up_next;
            env_per_reg   <= env_per_next;
            env_cnt_reg   <= env_cnt_next;
            env_run_reg   <= env_run_next;
            level_reg     <= level_next;
        end
    end

    assign result.channel_on   = chan_on_reg;
    assign result.sample_level = level_reg;

`ifndef SYNTHESIS
    // level only moves on a frequency tick
    a_level_only_on_freq: assert property (@(posedge clk) disable iff (!rst_n)
        !(en && item.op == lfsrn_pkg::OP_FREQ) |=> $stable(level_reg))
        else $error("sample level changed outside a frequency tick");

    // a restart write turns the channel on with a nonzero length
    a_restart_on: assert property (@(posedge clk) disable iff (!rst_n)
        (en && item.op == lfsrn_pkg::OP_WRITE && item.reg_index == lfsrn_pkg::REG_CTRL
         && item.write_data[7]) |=> (chan_on_reg && len_cnt_reg != '0))
        else $error("restart did not enable the channel");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_cnt_reg <= lfsrn_pkg::LEN_FULL)
        else $error("length counter above full length");
`endif

endmodule

[rtl/lfsr_noise_channel.sv]
// lfsr_noise_channel: top level of the noise sound channel, stream handshakes
// depends on lfsrn_pkg and lfsrn_core

// usage
//   s_* channel: one event per transfer; s_tuser holds the kind (register write,
//     frequency tick, length tick, envelope tick), s_tdata the register index
//     and the data byte used by a register write
//   m_* channel: one result per event, the output level and the channel-on flag
//     as they stand right after that event
//   cfg_* channel: writes divisor table entry cfg_index; cfg_ready is always high,
//     writes are expected only while no event is in flight
// throughput: one event per cycle while m_tready is high; the whole state update
//   is a single pass of logic between the input stage and the channel state
//   registers, which double as the result register
// reset: all channel state clears, the divisor table returns to
//   8, 16, 32, 48, 64, 80, 96, 112, both stream stages empty
// stall: while m_tready is low the result holds, the input stage still takes one
//   more event, and s_tready drops once that stage is full

module lfsr_noise_channel (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] reg_index, [9:2] write_data, [15:10] zero
    input  logic [1:0]  s_tuser,   // [1:0] op

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] sample_level, [4] channel_on, [7:5] zero

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic               in_valid_reg, in_valid_next;
    lfsrn_pkg::item_t   in_item_reg;
    logic               out_valid_reg, out_valid_next;
    logic               s_xfer;
    logic               advance;
    lfsrn_pkg::result_t result;

    // an event moves into the channel state when the result slot is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_item_reg.op         <= s_tuser;
            in_item_reg.reg_index  <= s_tdata[1:0];
            in_item_reg.write_data <= s_tdata[9:2];
        end
    end

    lfsrn_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .en        (advance),
        .item      (in_item_reg),
        .result    (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, result.channel_on, result.sample_level};

`ifndef SYNTHESIS
    // input stage only backs up behind a stalled, full result slot
    a_ready_low_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full stalled output");

    // every event that enters the channel state yields a result next cycle
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed event produced no result");
`endif

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for the lfsr noise channel
// drives events on the input stream and divisor writes on the config channel;
// depends on lfsrn_pkg and lfsr_noise_channel

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_CYCLES  = 8;       // settling margin after the last result is back
    localparam int PHASE_EVENTS = 85;
    localparam int PRINT_CAP    = 30;
    localparam logic [1:0] NO_REG = lfsrn_pkg::REG_LENGTH;  // index field, unused on ticks

    // divisor table settings, one per random phase
    localparam int SET_ALL_MIN   = 0;
    localparam int SET_WITH_ZERO = 1;
    localparam int SET_MIN_MAX   = 2;
    localparam int SET_RANDOM    = 3;

    // -------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // -------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = lfsrn_pkg::OP_WRITE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    // typed expectation that travels alongside the event being offered
    logic               tag_typed  = 1'b0;
    lfsrn_pkg::result_t tag_result = '0;

    always #5 clk = ~clk;

    lfsr_noise_channel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // -------------------------------------------------------------------------
    // channel mirror: state as it stands after every accepted event
    // -------------------------------------------------------------------------
    lfsrn_pkg::div_t div_tab [lfsrn_pkg::DIV_COUNT] = '{8'd8, 8'd16, 8'd32, 8'd48,
                                                        8'd64, 8'd80, 8'd96, 8'd112};
    int          freq_cnt   = 0;
    logic [14:0] lfsr       = '0;
    logic        narrow     = 1'b0;
    logic [3:0]  shift_amt  = '0;
    logic [2:0]  div_sel    = '0;
    int          len_cnt    = 0;
    logic        len_stop   = 1'b0;
    logic        chan_on    = 1'b0;
    logic        dac_en     = 1'b0;
    logic [3:0]  vol_start  = '0;
    logic [3:0]  vol_cur    = '0;
    logic        env_rise   = 1'b0;
    int          env_per    = 0;
    int          env_cnt    = 0;
    logic        env_act    = 1'b0;
    logic [3:0]  level_q    = '0;

    lfsrn_pkg::result_t pending_levels [$];

    int mismatches      = 0;
    int results_checked = 0;
    int events_sent     = 0;
    int timer_expiries  = 0;
    int length_cutoffs  = 0;
    int cycle_count     = 0;
    int burst_left      = 0;

    function automatic int timer_reload();
        return int'(div_tab[div_sel]) << shift_amt;
    endfunction

    // apply one event to the mirror and return the level and on flag after it
    function automatic lfsrn_pkg::result_t advance_channel(input lfsrn_pkg::item_t ev);
        logic               fb;
        lfsrn_pkg::result_t res;
        case (ev.op)
            lfsrn_pkg::OP_WRITE:
                case (ev.reg_index)
                    lfsrn_pkg::REG_LENGTH: len_cnt = int'(ev.write_data[5:0]);
                    lfsrn_pkg::REG_ENV:
                    begin
                        dac_en    = (ev.write_data[7:3] != 5'd0);
                        vol_start = ev.write_data[7:4];
                        vol_cur   = ev.write_data[7:4];
                        env_rise  = ev.write_data[3];
                        env_per   = int'(ev.write_data[2:0]);
                        env_cnt   = env_per;
                    end
                    lfsrn_pkg::REG_POLY:
                    begin
                        shift_amt = ev.write_data[7:4];
                        narrow    = ev.write_data[3];
                        div_sel   = ev.write_data[2:0];
                    end
                    default:
                    begin
                        len_stop = ev.write_data[6];
                        // trigger bit restarts the channel
                        if (ev.write_data[7])
                        begin
                            chan_on = 1'b1;
                            if (len_cnt == 0)
                                len_cnt = int'(lfsrn_pkg::LEN_FULL);
                            freq_cnt = timer_reload();
                            env_act  = 1'b1;
                            env_cnt  = env_per;
                            vol_cur  = vol_start;
                            lfsr     = lfsrn_pkg::LFSR_SEED;
                        end
                    end
                endcase
            lfsrn_pkg::OP_FREQ:
            begin
                freq_cnt = freq_cnt - 1;
                if (freq_cnt <= 0)
                begin
                    timer_expiries++;
                    freq_cnt = timer_reload();
                    fb       = lfsr[0] ^ lfsr[1];
                    lfsr     = {fb, lfsr[14:1]};
                    if (narrow)
                        lfsr[lfsrn_pkg::NARROW_TAP] = fb;
                    level_q = (!lfsr[0] && chan_on && dac_en) ? vol_cur : 4'd0;
                end
            end
            lfsrn_pkg::OP_LEN:
                if (len_cnt > 0 && len_stop)
                begin
                    len_cnt = len_cnt - 1;
                    if (len_cnt == 0)
                    begin
                        if (chan_on)
                            length_cutoffs++;
                        chan_on = 1'b0;
                    end
                end
            default:
            begin
                env_cnt = env_cnt - 1;
                if (env_cnt <= 0)
                begin
                    env_cnt = env_per;
                    if (env_act && env_per > 0)
                    begin
                        if (env_rise && vol_cur < lfsrn_pkg::VOL_MAX)
                            vol_cur = vol_cur + 4'd1;
                        else if (!env_rise && vol_cur > 4'd0)
                            vol_cur = vol_cur - 4'd1;
                    end
                    // envelope parks at either end until the next restart
                    if (vol_cur == 4'd0 || vol_cur == lfsrn_pkg::VOL_MAX)
                        env_act = 1'b0;
                end
            end
        endcase
        res.sample_level = level_q;
        res.channel_on   = chan_on;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch at result %0d: %s, expected %0d, got %0d",
                     $realtime, results_checked, what, want_v, got_v);
    endtask

    // -------------------------------------------------------------------------
    // monitor: outputs sampled at the rising edge
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin
        lfsrn_pkg::item_t   ev;
        lfsrn_pkg::result_t got;
        lfsrn_pkg::result_t want;
        lfsrn_pkg::result_t pred;
        if (rst_n)
        begin
            // result transfer, checked against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                got.sample_level = m_tdata[3:0];
                got.channel_on   = m_tdata[4];
                results_checked++;
                if (pending_levels.size() == 0)
                    report_mismatch("result with nothing pending", -1, int'(got));
                else
                begin
                    want = pending_levels.pop_front();
                    if (got.sample_level != want.sample_level)
                        report_mismatch("sample_level", want.sample_level, got.sample_level);
                    if (got.channel_on != want.channel_on)
                        report_mismatch("channel_on", want.channel_on, got.channel_on);
                end
            end
            // event transfer, run through the mirror
            if (s_tvalid && s_tready)
            begin
                ev.op         = s_tuser;
                ev.reg_index  = s_tdata[1:0];
                ev.write_data = s_tdata[9:2];
                pred          = advance_channel(ev);
                pending_levels.push_back(tag_typed ? tag_result : pred);
            end
            // divisor write transfer
            if (cfg_valid && cfg_ready)
                div_tab[cfg_index] = cfg_data;
        end
    end

    // -------------------------------------------------------------------------
    // receiver: stalls on a rotating 16-bit pattern, redrawn when its age counter runs out of cycles
    // -------------------------------------------------------------------------
    logic [15:0] ready_pat = '1;
    int          pat_age   = 0;

    always @(negedge clk)
    begin
        if (pat_age == 0)
        begin
            pat_age = 64;
            case ($urandom_range(0, 3))
                0:       ready_pat = '1;                          // no stalls
                1:       ready_pat = 16'($urandom);
                2:       ready_pat = 16'($urandom) | 16'($urandom); // light stalls
                default: ready_pat = 16'($urandom) & 16'($urandom); // heavy stalls
            endcase
            ready_pat[0] = 1'b1;
        end
        pat_age   = pat_age - 1;
        m_tready <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[15:1]};
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run timed out after %0d cycles, %0d results still pending",
                 cycle_count, pending_levels.size());
        $display("Regression FAIL");
        $finish;
    end

    // -------------------------------------------------------------------------
    // sender side
    // -------------------------------------------------------------------------

    // offer one event in bursts with random gaps, return at its transfer edge
    task automatic push_event(input lfsrn_pkg::item_t ev, input logic typed,
                              input lfsrn_pkg::result_t typed_res);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(40, 80);   // long run with no idling
            end
            else
            begin
                gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 20);
            end
            repeat (gap)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        burst_left = burst_left - 1;
        s_tvalid   <= 1'b1;
        s_tuser    <= ev.op;
        s_tdata    <= {6'd0, ev.write_data, ev.reg_index};
        tag_typed  <= typed;
        tag_result <= typed_res;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        events_sent++;
    endtask

    task automatic send_write(input logic [1:0] idx, input logic [7:0] data);
        lfsrn_pkg::item_t ev;
        ev.op         = lfsrn_pkg::OP_WRITE;
        ev.reg_index  = idx;
        ev.write_data = data;
        push_event(ev, 1'b0, '0);
    endtask

    task automatic send_tick(input logic [1:0] op);
        lfsrn_pkg::item_t ev;
        ev.op         = op;
        ev.reg_index  = 2'($urandom);     // ignored on ticks, toggled anyway
        ev.write_data = 8'($urandom);
        push_event(ev, 1'b0, '0);
    endtask

    // hold off the sender until every result is back, then let the pipe settle
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    // load one divisor table setting through the config channel
    task automatic apply_setting(input int kind);
        logic [7:0] val;
        for (int i = 0; i < lfsrn_pkg::DIV_COUNT; i++)
        begin
            case (kind)
                SET_ALL_MIN:   val = 8'd1;
                SET_WITH_ZERO: val = (i % 2 == 0) ? 8'd0 : 8'($urandom_range(1, 3));
                SET_MIN_MAX:   val = (i % 2 == 0) ? 8'd255 : 8'd1;
                default:       val = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                                 : 8'($urandom_range(1, 6));
            endcase
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= val;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly full sound programs (envelope, polynomial, length, trigger, then a
    // run of ticks), the rest loose noise events
    task automatic run_sound_programs(input int n_events);
        int               start;
        int               run_len;
        int               pick;
        logic [7:0]       data;
        lfsrn_pkg::item_t ev;
        start = events_sent;
        while (events_sent - start < n_events)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    ev.op         = 2'($urandom);
                    ev.reg_index  = 2'($urandom);
                    ev.write_data = 8'($urandom);
                    push_event(ev, 1'b0, '0);
                end
            end
            else
            begin
                send_write(lfsrn_pkg::REG_ENV, 8'($urandom));
                // short shifts keep timer expiries frequent
                data = 8'($urandom);
                if ($urandom_range(0, 7) != 0)
                    data[7:4] = 4'($urandom_range(0, 2));
                send_write(lfsrn_pkg::REG_POLY, data);
                // short lengths so the length counter runs out now and then
                data = 8'($urandom);
                if ($urandom_range(0, 3) != 0)
                    data[5:0] = 6'($urandom_range(0, 5));
                send_write(lfsrn_pkg::REG_LENGTH, data);
                data    = 8'($urandom);
                data[7] = ($urandom_range(0, 7) != 0);
                send_write(lfsrn_pkg::REG_CTRL, data);
                run_len = $urandom_range(10, 40);
                repeat (run_len)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        send_tick(lfsrn_pkg::OP_FREQ);
                    else if (pick < 8)
                        send_tick(lfsrn_pkg::OP_LEN);
                    else
                        send_tick(lfsrn_pkg::OP_ENV);
                end
            end
        end
    endtask

    // -------------------------------------------------------------------------
    // directed steps, run with the reset divisor table
    // rows with typed set carry their own expectation, the others use the mirror
    // -------------------------------------------------------------------------
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] idx;
        logic [7:0] data;
        logic       typed;
        logic [3:0] level;
        logic       on;
    } step_t;

    step_t dir_tab [25] = '{
        // expires at once after reset
        '{lfsrn_pkg::OP_FREQ,  NO_REG,                8'h00, 1'b1, 4'd0, 1'b0},
        '{lfsrn_pkg::OP_LEN,   NO_REG,                8'h00, 1'b1, 4'd0, 1'b0},
        '{lfsrn_pkg::OP_ENV,   NO_REG,                8'h00, 1'b1, 4'd0, 1'b0},
        // full volume, period zero
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_ENV,    8'hF0, 1'b1, 4'd0, 1'b0},
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_POLY,   8'h00, 1'b1, 4'd0, 1'b0},
        // length field max
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_LENGTH, 8'hFF, 1'b1, 4'd0, 1'b0},
        // stop on length, no trigger
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_CTRL,   8'h40, 1'b1, 4'd0, 1'b0},
        '{lfsrn_pkg::OP_LEN,   NO_REG,                8'hFF, 1'b1, 4'd0, 1'b0},
        // zero length, reloads as 64
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_LENGTH, 8'h00, 1'b1, 4'd0, 1'b0},
        // trigger
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_CTRL,   8'hC0, 1'b1, 4'd0, 1'b1},
        // period zero keeps volume
        '{lfsrn_pkg::OP_ENV,   NO_REG,                8'h00, 1'b1, 4'd0, 1'b1},
        // volume 1, rising, period 1
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_ENV,    8'h19, 1'b1, 4'd0, 1'b1},
        // trigger with stop clear
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_CTRL,   8'h80, 1'b1, 4'd0, 1'b1},
        '{lfsrn_pkg::OP_ENV,   NO_REG,                8'h00, 1'b1, 4'd0, 1'b1},
        // stop clear, length frozen
        '{lfsrn_pkg::OP_LEN,   NO_REG,                8'h00, 1'b1, 4'd0, 1'b1},
        // dac off, volume 0, falling
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_ENV,    8'h01, 1'b1, 4'd0, 1'b1},
        // max shift, narrow, select 7
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_POLY,   8'hFF, 1'b1, 4'd0, 1'b1},
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_CTRL,   8'hFF, 1'b1, 4'd0, 1'b1},
        // envelope parks at zero
        '{lfsrn_pkg::OP_ENV,   NO_REG,                8'h00, 1'b1, 4'd0, 1'b1},
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_POLY,   8'h08, 1'b1, 4'd0, 1'b1},
        // volume 15, rising
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_ENV,    8'hF9, 1'b1, 4'd0, 1'b1},
        '{lfsrn_pkg::OP_WRITE, lfsrn_pkg::REG_CTRL,   8'h80, 1'b1, 4'd0, 1'b1},
        '{lfsrn_pkg::OP_FREQ,  NO_REG,                8'h00, 1'b0, 4'd0, 1'b0},
        // envelope parks at 15
        '{lfsrn_pkg::OP_ENV,   NO_REG,                8'h00, 1'b1, 4'd0, 1'b1},
        '{lfsrn_pkg::OP_LEN,   NO_REG,                8'h00, 1'b0, 4'd0, 1'b0}
    };

    initial
    begin
        lfsrn_pkg::item_t   ev;
        lfsrn_pkg::result_t res;
        int                 kinds [4];

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            ev.op            = dir_tab[i].op;
            ev.reg_index     = dir_tab[i].idx;
            ev.write_data    = dir_tab[i].data;
            res.sample_level = dir_tab[i].level;
            res.channel_on   = dir_tab[i].on;
            push_event(ev, dir_tab[i].typed, res);
        end
        wait_idle();

        kinds = '{SET_ALL_MIN, SET_WITH_ZERO, SET_MIN_MAX, SET_RANDOM};
        foreach (kinds[p])
        begin
            apply_setting(kinds[p]);
            if (kinds[p] == SET_WITH_ZERO)
            begin
                // zero divisor on select 0: the timer expires on every tick
                send_write(lfsrn_pkg::REG_ENV, 8'hF0);
                send_write(lfsrn_pkg::REG_POLY, 8'h00);
                send_write(lfsrn_pkg::REG_CTRL, 8'h80);
                repeat (6) send_tick(lfsrn_pkg::OP_FREQ);
            end
            run_sound_programs(PHASE_EVENTS);
            wait_idle();
        end

        if (pending_levels.size() != 0)
            report_mismatch("results never delivered", 0, pending_levels.size());

        $display("covered %0d events over the reset table and 4 divisor settings",
                 events_sent);
        $display("%0d results checked, %0d timer expiries, %0d length cut-offs, %0d mismatches",
                 results_checked, timer_expiries, length_cutoffs, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/lfsrn_pkg.sv
rtl/lfsrn_core.sv
rtl/lfsr_noise_channel.sv
tb/tb_top.sv
